>>> rtl/core/dfd_pkg.sv
// dfd_pkg: shared types, constants and helpers of the deauth flood detector
// depends on nothing; used by the interfaces, the table cell and the top level
package dfd_pkg;

  localparam int MacW     = 48;
  localparam int TimeW    = 32;
  localparam int CountW   = 16;
  localparam int FlagW    = 3;
  localparam int CfgW     = 32;
  localparam int CfgIdxW  = 2;
  localparam int OutcomeW = 2;

  // frame control byte decoding
  localparam logic [7:0] FC_TYPE_MASK     = 8'h0C;
  localparam logic [7:0] FC_SUBTYPE_MASK  = 8'hF0;
  localparam logic [7:0] SUBTYPE_DEAUTH   = 8'hC0;
  localparam logic [7:0] SUBTYPE_DISASSOC = 8'hA0;
  localparam logic [7:0] BYTE_ALL_ONES    = 8'hFF;

  localparam logic [CountW-1:0] COUNT_MAX = '1;

  // kind flag bit positions
  localparam int FLAG_DEAUTH   = 0;
  localparam int FLAG_DISASSOC = 1;
  localparam int FLAG_BCAST    = 2;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] REG_WINDOW_LENGTH   = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_ALERT_THRESHOLD = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_ALERT_HOLD      = 2'd2;

  localparam logic [TimeW-1:0]  WINDOW_RESET    = 32'd1000;
  localparam logic [CountW-1:0] THRESHOLD_RESET = 16'd10;
  localparam logic [TimeW-1:0]  HOLD_RESET      = 32'd5000;

  // result outcome codes
  localparam logic [OutcomeW-1:0] OUT_IGNORED = 2'd0;
  localparam logic [OutcomeW-1:0] OUT_COUNTED = 2'd1;
  localparam logic [OutcomeW-1:0] OUT_READ    = 2'd2;
  localparam logic [OutcomeW-1:0] OUT_EMPTY   = 2'd3;

  // one table entry
  typedef struct packed {
    logic [MacW-1:0]   bssid;
    logic [TimeW-1:0]  start;
    logic [CountW-1:0] total;
    logic [CountW-1:0] deauth;
    logic [CountW-1:0] disassoc;
    logic [CountW-1:0] bcast;
    logic [FlagW-1:0]  flags;
    logic              alert;
    logic [TimeW-1:0]  alert_time;
  } dfd_rec_t;

  // transaction data broadcast to every cell
  typedef struct packed {
    logic [MacW-1:0]   key;
    logic [TimeW-1:0]  now;
    logic [TimeW-1:0]  window;
    logic [TimeW-1:0]  hold;
    logic [CountW-1:0] threshold;
    logic              deauth_fr;
    logic              disassoc_fr;
    logic              is_bcast;
  } dfd_bus_t;

  // per-cell commands for the update cycle
  typedef struct packed {
    logic shift;
    logic load;
    logic count;
    logic rd;
  } dfd_ctl_t;

  function automatic logic [CountW-1:0] sat_inc(input logic [CountW-1:0] v);
    sat_inc = (v == COUNT_MAX) ? COUNT_MAX : v + 1'b1;
  endfunction

endpackage

>>> rtl/core/dfd_frame_if.sv
// dfd_frame_if: valid/ready channel carrying one captured frame or read command
// depends on dfd_pkg for field widths
interface dfd_frame_if import dfd_pkg::*; #(
  parameter int SLOT_W = 3
) ();
  logic              valid;
  logic              ready;
  logic              cmd;
  logic              is_management;
  logic [7:0]        frame_control;
  logic [MacW-1:0]   receiver_address;
  logic [MacW-1:0]   bssid_address;
  logic [TimeW-1:0]  time_ms;
  logic [SLOT_W-1:0] entry_index;

  modport source (
    output valid, cmd, is_management, frame_control, receiver_address, bssid_address,
           time_ms, entry_index,
    input  ready
  );

  modport sink (
    input  valid, cmd, is_management, frame_control, receiver_address, bssid_address,
           time_ms, entry_index,
    output ready
  );
endinterface

>>> rtl/core/dfd_result_if.sv
// dfd_result_if: valid/ready channel carrying one result of the detector
// depends on dfd_pkg for field widths
interface dfd_result_if import dfd_pkg::*; #(
  parameter int SLOT_W = 3
) ();
  logic                valid;
  logic                ready;
  logic [OutcomeW-1:0] outcome;
  logic [SLOT_W-1:0]   slot;
  logic [MacW-1:0]     entry_bssid;
  logic [CountW-1:0]   total_frames;
  logic [CountW-1:0]   deauth_frames;
  logic [CountW-1:0]   disassoc_frames;
  logic [CountW-1:0]   broadcast_frames;
  logic [FlagW-1:0]    kind_flags;
  logic                alert;
  logic [TimeW-1:0]    last_alert_time;

  modport source (
    output valid, outcome, slot, entry_bssid, total_frames, deauth_frames,
           disassoc_frames, broadcast_frames, kind_flags, alert, last_alert_time,
    input  ready
  );

  modport sink (
    input  valid, outcome, slot, entry_bssid, total_frames, deauth_frames,
           disassoc_frames, broadcast_frames, kind_flags, alert, last_alert_time,
    output ready
  );
endinterface

>>> rtl/core/deauth_flood_detector.sv
// deauth_flood_detector: per-bssid deauth/disassoc flood detection over a row of table cells
// result path: the input transaction is registered, passes the match state, then the update
// state, which loads the result register; a new transaction is taken only in idle or as the
// last one commits; a stalled result holds the update cycle until the result register frees
// reset: sync active high; clears control, entry count and config to defaults, not table data
module deauth_flood_detector import dfd_pkg::*; #(
  parameter int TABLE_DEPTH = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [CfgW-1:0]    cfg_data,
  dfd_frame_if.sink          frame,
  dfd_result_if.source       result
);

  localparam int SlotW = $clog2(TABLE_DEPTH);
  localparam int CntW  = $clog2(TABLE_DEPTH + 1);
  localparam logic [CntW-1:0] FullCount = CntW'(TABLE_DEPTH);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_MATCH  = 2'd1;
  localparam logic [1:0] ST_UPDATE = 2'd2;

  logic [1:0]        state;
  logic [1:0]        state_next;
  logic [CntW-1:0]   used;
  logic [CntW-1:0]   used_next;

  logic [TimeW-1:0]  window_length;
  logic [CountW-1:0] threshold;
  logic [TimeW-1:0]  hold_length;

  logic              req_cmd;
  logic              req_ign;
  logic              req_deauth;
  logic              req_disassoc;
  logic              req_bcast;
  logic [MacW-1:0]   req_key;
  logic [TimeW-1:0]  req_now;
  logic [SlotW-1:0]  req_idx;

  logic              in_accept;
  logic              commit;
  logic              out_free;
  logic              out_valid;
  logic              fr_deauth;
  logic              fr_disassoc;
  logic              fr_ign;

  dfd_bus_t          bus;
  dfd_rec_t          rec_q   [TABLE_DEPTH];
  dfd_rec_t          rec_nx  [TABLE_DEPTH];
  dfd_ctl_t          ctl     [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] hitv;
  logic [TABLE_DEPTH-1:0] tgt;
  logic              any_hit;
  logic              rd_ok;
  logic              full;
  logic              add_new;
  dfd_rec_t          sel_rec;
  logic [SlotW-1:0]  sel_slot;

  logic [OutcomeW-1:0] out_outcome;
  logic [SlotW-1:0]    out_slot;
  dfd_rec_t            out_rec;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      window_length <= WINDOW_RESET;
      threshold     <= THRESHOLD_RESET;
      hold_length   <= HOLD_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WINDOW_LENGTH:   window_length <= cfg_data[TimeW-1:0];
        REG_ALERT_THRESHOLD: threshold     <= cfg_data[CountW-1:0];
        REG_ALERT_HOLD:      hold_length   <= cfg_data[TimeW-1:0];
        default: ;
      endcase
    end
  end

  // frame classification at the input
  assign fr_deauth   = (frame.frame_control & FC_SUBTYPE_MASK) == SUBTYPE_DEAUTH;
  assign fr_disassoc = (frame.frame_control & FC_SUBTYPE_MASK) == SUBTYPE_DISASSOC;
  assign fr_ign      = !frame.is_management || (frame.bssid_address == '0) ||
                       ((frame.frame_control & FC_TYPE_MASK) != '0) ||
                       !(fr_deauth || fr_disassoc);

  assign out_free    = !out_valid || result.ready;
  assign commit      = (state == ST_UPDATE) && out_free;
  assign frame.ready = (state == ST_IDLE) || commit;
  assign in_accept   = frame.valid && frame.ready;

  always_ff @(posedge clk) begin
    if (in_accept) begin
      req_cmd      <= frame.cmd;
      req_ign      <= fr_ign;
      req_deauth   <= fr_deauth;
      req_disassoc <= fr_disassoc;
      req_bcast    <= frame.receiver_address == {6{BYTE_ALL_ONES}};
      req_key      <= frame.bssid_address;
      req_now      <= frame.time_ms;
      req_idx      <= frame.entry_index;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (in_accept) state_next = ST_MATCH;
      ST_MATCH:  state_next = ST_UPDATE;
      ST_UPDATE: begin
        if (in_accept) begin
          state_next = ST_MATCH;
        end else if (commit) begin
          state_next = ST_IDLE;
        end
      end
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      used  <= '0;
    end else begin
      state <= state_next;
      used  <= used_next;
    end
  end

  assign bus.key         = req_key;
  assign bus.now         = req_now;
  assign bus.window      = window_length;
  assign bus.hold        = hold_length;
  assign bus.threshold   = threshold;
  assign bus.deauth_fr   = req_deauth;
  assign bus.disassoc_fr = req_disassoc;
  assign bus.is_bcast    = req_bcast;

  // row of cells, each shifting toward slot 0 on eviction
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    dfd_rec_t nbr;
    if (i < TABLE_DEPTH - 1) begin : g_mid
      assign nbr = rec_q[i+1];
    end else begin : g_end
      assign nbr = '0;
    end
    dfd_cell u_cell (
      .clk      (clk),
      .probe    (state == ST_MATCH),
      .in_use   (CntW'(i) < used),
      .bus      (bus),
      .ctl      (ctl[i]),
      .nbr      (nbr),
      .rec      (rec_q[i]),
      .rec_next (rec_nx[i]),
      .hit      (hitv[i])
    );
  end

  assign any_hit = |hitv;
  assign rd_ok   = CntW'(req_idx) < used;
  assign full    = used == FullCount;
  assign add_new = !req_cmd && !req_ign && !any_hit;

  // target slot selection and per-cell commands
  always_comb begin
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      ctl[i] = '0;
      tgt[i] = 1'b0;
      if (req_cmd) begin
        tgt[i] = rd_ok && (req_idx == SlotW'(i));
      end else if (!req_ign) begin
        if (any_hit) begin
          tgt[i] = hitv[i];
        end else if (full) begin
          tgt[i] = i == TABLE_DEPTH - 1;
        end else begin
          tgt[i] = used == CntW'(i);
        end
      end
      if (commit) begin
        ctl[i].rd    = req_cmd && tgt[i];
        ctl[i].count = !req_cmd && tgt[i];
        ctl[i].load  = add_new && tgt[i];
        ctl[i].shift = add_new && full && (i < TABLE_DEPTH - 1);
      end
    end
  end

  // one-hot mux of the selected cell's next contents
  always_comb begin
    sel_rec  = '0;
    sel_slot = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (tgt[i]) begin
        sel_rec  = dfd_rec_t'(sel_rec | rec_nx[i]);
        sel_slot = sel_slot | SlotW'(i);
      end
    end
  end

  assign used_next = (commit && add_new && !full) ? used + 1'b1 : used;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (commit) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_rec <= sel_rec;
      if (req_cmd) begin
        out_outcome <= rd_ok ? OUT_READ : OUT_EMPTY;
        out_slot    <= req_idx;
      end else begin
        out_outcome <= req_ign ? OUT_IGNORED : OUT_COUNTED;
        out_slot    <= sel_slot;
      end
    end
  end

  assign result.valid            = out_valid;
  assign result.outcome          = out_outcome;
  assign result.slot             = out_slot;
  assign result.entry_bssid      = out_rec.bssid;
  assign result.total_frames     = out_rec.total;
  assign result.deauth_frames    = out_rec.deauth;
  assign result.disassoc_frames  = out_rec.disassoc;
  assign result.broadcast_frames = out_rec.bcast;
  assign result.kind_flags       = out_rec.flags;
  assign result.alert            = out_rec.alert;
  assign result.last_alert_time  = out_rec.alert_time;

endmodule

>>> rtl/core/dfd_cell.sv
// dfd_cell: one slot of the bssid table; matches, ages, counts and shifts
// depends on dfd_pkg (dfd_rec_t, dfd_bus_t, dfd_ctl_t, sat_inc)
module dfd_cell import dfd_pkg::*; (
  input  logic     clk,
  input  logic     probe,
  input  logic     in_use,
  input  dfd_bus_t bus,
  input  dfd_ctl_t ctl,
  input  dfd_rec_t nbr,
  output dfd_rec_t rec,
  output dfd_rec_t rec_next,
  output logic     hit
);

  logic win_exp;
  logic hold_exp;

  // compare and age checks are registered in the probe cycle, the cycle before the update
  always_ff @(posedge clk) begin
    if (probe) begin
      hit      <= in_use && (rec.bssid == bus.key);
      win_exp  <= (bus.now - rec.start) > bus.window;
      hold_exp <= rec.alert && ((bus.now - rec.alert_time) > bus.hold);
    end
    rec <= rec_next;
  end

  always_comb begin
    dfd_rec_t          base;
    dfd_rec_t          fresh;
    logic [CountW-1:0] total_n;
    fresh       = '0;
    fresh.bssid = bus.key;
    fresh.start = bus.now;
    base        = ctl.shift ? nbr : rec;
    if (ctl.load) begin
      base = fresh;
    end
    rec_next = base;
    total_n  = '0;
    if (ctl.count) begin
      // window restart, a fresh entry starts at zero anyway
      if (!ctl.load && win_exp) begin
        rec_next.total    = '0;
        rec_next.deauth   = '0;
        rec_next.disassoc = '0;
        rec_next.bcast    = '0;
        rec_next.flags    = '0;
        rec_next.start    = bus.now;
      end
      total_n        = sat_inc(rec_next.total);
      rec_next.total = total_n;
      if (bus.deauth_fr) begin
        rec_next.deauth             = sat_inc(rec_next.deauth);
        rec_next.flags[FLAG_DEAUTH] = 1'b1;
      end
      if (bus.disassoc_fr) begin
        rec_next.disassoc             = sat_inc(rec_next.disassoc);
        rec_next.flags[FLAG_DISASSOC] = 1'b1;
      end
      if (bus.is_bcast) begin
        rec_next.bcast             = sat_inc(rec_next.bcast);
        rec_next.flags[FLAG_BCAST] = 1'b1;
      end
      if (total_n >= bus.threshold) begin
        rec_next.alert      = 1'b1;
        rec_next.alert_time = bus.now;
      end
    end
    if (ctl.rd && hold_exp) begin
      rec_next.alert = 1'b0;
    end
  end

endmodule

>>> verif/dfd_checker.sv
// dfd_checker: predicts every result of the deauth flood detector and checks the result channel
// depends on dfd_pkg and on the dfd_frame_if / dfd_result_if channel interfaces
module dfd_checker import dfd_pkg::*; #(
  parameter int TABLE_DEPTH = 8,
  parameter int SLOT_W      = 3
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [CfgW-1:0]    cfg_data,
  dfd_frame_if               frame,
  dfd_result_if              result,
  output int                 errors,
  output int                 backlog,
  output int                 reports_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [OutcomeW-1:0] outcome;
    logic [SLOT_W-1:0]   slot;
    logic [MacW-1:0]     bssid;
    logic [CountW-1:0]   total;
    logic [CountW-1:0]   deauth;
    logic [CountW-1:0]   disassoc;
    logic [CountW-1:0]   bcast;
    logic [FlagW-1:0]    flags;
    logic                alert;
    logic [TimeW-1:0]    alert_time;
  } ap_report_t;

  dfd_rec_t          ap_table [TABLE_DEPTH];
  int                ap_count;
  logic [TimeW-1:0]  window_ms;
  logic [TimeW-1:0]  hold_ms;
  logic [CountW-1:0] threshold;
  ap_report_t        reports_due [$];
  int                mismatches;
  int                seen_count;

  function automatic logic [CountW-1:0] count_up(input logic [CountW-1:0] v);
    return (v == COUNT_MAX) ? v : v + 1'b1;
  endfunction

  function automatic ap_report_t report_of(input logic [OutcomeW-1:0] outcome,
                                           input logic [SLOT_W-1:0] slot, input dfd_rec_t r);
    ap_report_t rep;
    rep.outcome    = outcome;
    rep.slot       = slot;
    rep.bssid      = r.bssid;
    rep.total      = r.total;
    rep.deauth     = r.deauth;
    rep.disassoc   = r.disassoc;
    rep.bcast      = r.bcast;
    rep.flags      = r.flags;
    rep.alert      = r.alert;
    rep.alert_time = r.alert_time;
    return rep;
  endfunction

  // updates the table copy for one transaction and returns the result it causes
  function automatic ap_report_t predict_item(input logic cmd, input logic mgmt,
                                              input logic [7:0] fc,
                                              input logic [MacW-1:0] rx,
                                              input logic [MacW-1:0] bssid,
                                              input logic [TimeW-1:0] now,
                                              input logic [SLOT_W-1:0] idx);
    ap_report_t rep;
    logic [7:0] subtype;
    logic       deauth_fr;
    logic       disassoc_fr;
    logic       is_bcast;
    int         s;
    rep = '0;
    if (cmd) begin
      rep.outcome = OUT_EMPTY;
      rep.slot    = idx;
      if (int'(idx) < ap_count) begin
        // alert drops only once the hold time has run out, wrapping time
        if (ap_table[idx].alert && TimeW'(now - ap_table[idx].alert_time) > hold_ms)
          ap_table[idx].alert = 1'b0;
        rep = report_of(OUT_READ, idx, ap_table[idx]);
      end
      return rep;
    end
    if (!mgmt || bssid == '0 || (fc & FC_TYPE_MASK) != 8'h00)
      return rep;
    subtype     = fc & FC_SUBTYPE_MASK;
    deauth_fr   = (subtype == SUBTYPE_DEAUTH);
    disassoc_fr = (subtype == SUBTYPE_DISASSOC);
    if (!deauth_fr && !disassoc_fr)
      return rep;
    is_bcast = (rx == '1);

    s = -1;
    for (int i = 0; i < ap_count; i++)
      if (s < 0 && ap_table[i].bssid == bssid) s = i;
    if (s < 0) begin
      // full table: oldest entry falls out of slot 0
      if (ap_count == TABLE_DEPTH) begin
        for (int i = 0; i < TABLE_DEPTH - 1; i++) ap_table[i] = ap_table[i + 1];
        ap_count = TABLE_DEPTH - 1;
      end
      s = ap_count;
      ap_table[s]       = '0;
      ap_table[s].bssid = bssid;
      ap_table[s].start = now;
      ap_count++;
    end

    if (TimeW'(now - ap_table[s].start) > window_ms) begin
      ap_table[s].total    = '0;
      ap_table[s].deauth   = '0;
      ap_table[s].disassoc = '0;
      ap_table[s].bcast    = '0;
      ap_table[s].flags    = '0;
      ap_table[s].start    = now;
    end
    ap_table[s].total = count_up(ap_table[s].total);
    if (deauth_fr) begin
      ap_table[s].deauth = count_up(ap_table[s].deauth);
      ap_table[s].flags[FLAG_DEAUTH] = 1'b1;
    end
    if (disassoc_fr) begin
      ap_table[s].disassoc = count_up(ap_table[s].disassoc);
      ap_table[s].flags[FLAG_DISASSOC] = 1'b1;
    end
    if (is_bcast) begin
      ap_table[s].bcast = count_up(ap_table[s].bcast);
      ap_table[s].flags[FLAG_BCAST] = 1'b1;
    end
    if (ap_table[s].total >= threshold) begin
      ap_table[s].alert      = 1'b1;
      ap_table[s].alert_time = now;
    end
    return report_of(OUT_COUNTED, SLOT_W'(s), ap_table[s]);
  endfunction

  function automatic void check_field(input string what, input logic [63:0] want,
                                      input logic [63:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("result %0d: %s expected %0h got %0h", seen_count, what, want, got);
    end
  endfunction

  always @(posedge clk) begin : watch
    ap_report_t want;
    if (rst) begin
      ap_count  = 0;
      window_ms = WINDOW_RESET;
      threshold = THRESHOLD_RESET;
      hold_ms   = HOLD_RESET;
      reports_due.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_WINDOW_LENGTH:   window_ms = cfg_data;
          REG_ALERT_THRESHOLD: threshold = cfg_data[CountW-1:0];
          REG_ALERT_HOLD:      hold_ms = cfg_data;
          default: ;
        endcase
      end
      if (result.valid && result.ready) begin
        seen_count++;
        if (reports_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result %0d: no result expected, outcome %0d slot %0d",
                     seen_count, result.outcome, result.slot);
        end else begin
          want = reports_due.pop_front();
          check_field("outcome", 64'(want.outcome), 64'(result.outcome));
          check_field("slot", 64'(want.slot), 64'(result.slot));
          check_field("entry_bssid", 64'(want.bssid), 64'(result.entry_bssid));
          check_field("total_frames", 64'(want.total), 64'(result.total_frames));
          check_field("deauth_frames", 64'(want.deauth), 64'(result.deauth_frames));
          check_field("disassoc_frames", 64'(want.disassoc), 64'(result.disassoc_frames));
          check_field("broadcast_frames", 64'(want.bcast), 64'(result.broadcast_frames));
          check_field("kind_flags", 64'(want.flags), 64'(result.kind_flags));
          check_field("alert", 64'(want.alert), 64'(result.alert));
          check_field("last_alert_time", 64'(want.alert_time),
                      64'(result.last_alert_time));
        end
      end
      if (frame.valid && frame.ready)
        reports_due.push_back(predict_item(frame.cmd, frame.is_management,
                                           frame.frame_control, frame.receiver_address,
                                           frame.bssid_address, frame.time_ms,
                                           frame.entry_index));
    end
    errors       <= mismatches;
    backlog      <= reports_due.size();
    reports_seen <= seen_count;
  end

endmodule

>>> verif/tb.sv
// tb: drives frames, read commands and register writes into the deauth flood detector
// depends on dfd_pkg, the channel interfaces, the detector and the dfd_checker module
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import dfd_pkg::*;

  localparam int TABLE_DEPTH  = 8;
  localparam int SLOT_W       = 3;
  localparam int CYCLE_LIMIT  = 200_000;
  localparam int RANDOM_ITEMS = 1000;
  localparam int BLOCKS       = 9;
  localparam int POOL_SIZE    = 12;

  localparam logic [CfgIdxW-1:0] REG_UNUSED     = 2'd3;
  localparam logic [7:0]         SUBTYPE_BEACON = 8'h80;

  typedef struct {
    logic              cmd;
    logic              mgmt;
    logic [7:0]        fc;
    logic [MacW-1:0]   rx;
    logic [MacW-1:0]   bssid;
    logic [TimeW-1:0]  t;
    logic [SLOT_W-1:0] idx;
  } frame_t;

  logic               clk;
  logic               rst;
  logic               cfg_we;
  logic [CfgIdxW-1:0] cfg_index;
  logic [CfgW-1:0]    cfg_data;
  int                 errors;
  int                 backlog;
  int                 reports_seen;
  int                 send_idle_pct;
  int                 recv_idle_pct;
  int                 frames_sent = 0;
  int                 cycles = 0;
  logic [MacW-1:0]    ap_pool [POOL_SIZE];
  logic [TimeW-1:0]   clock_ms;

  dfd_frame_if  #(.SLOT_W(SLOT_W)) frame_ch ();
  dfd_result_if #(.SLOT_W(SLOT_W)) result_ch ();

  deauth_flood_detector #(.TABLE_DEPTH(TABLE_DEPTH)) dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .frame     (frame_ch),
    .result    (result_ch)
  );

  dfd_checker #(.TABLE_DEPTH(TABLE_DEPTH), .SLOT_W(SLOT_W)) flood_chk (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .frame        (frame_ch),
    .result       (result_ch),
    .errors       (errors),
    .backlog      (backlog),
    .reports_seen (reports_seen)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else begin
      result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  function automatic frame_t frame_of(input logic cmd, input logic mgmt, input logic [7:0] fc,
                                      input logic [MacW-1:0] rx, input logic [MacW-1:0] bssid,
                                      input logic [TimeW-1:0] t, input logic [SLOT_W-1:0] idx);
    frame_t f;
    f.cmd   = cmd;
    f.mgmt  = mgmt;
    f.fc    = fc;
    f.rx    = rx;
    f.bssid = bssid;
    f.t     = t;
    f.idx   = idx;
    return f;
  endfunction

  function automatic logic [MacW-1:0] random_mac();
    return MacW'({$urandom, $urandom});
  endfunction

  task automatic offer_frame(input frame_t f);
    while ($urandom_range(99) < send_idle_pct) begin
      frame_ch.valid <= 1'b0;
      @(posedge clk);
    end
    frame_ch.valid            <= 1'b1;
    frame_ch.cmd              <= f.cmd;
    frame_ch.is_management    <= f.mgmt;
    frame_ch.frame_control    <= f.fc;
    frame_ch.receiver_address <= f.rx;
    frame_ch.bssid_address    <= f.bssid;
    frame_ch.time_ms          <= f.t;
    frame_ch.entry_index      <= f.idx;
    @(posedge clk);
    while (!frame_ch.ready) @(posedge clk);
    frames_sent++;
  endtask

  // hold off until every result is back, then let the pipeline empty
  task automatic settle();
    frame_ch.valid <= 1'b0;
    @(posedge clk);
    while (reports_seen != frames_sent) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apply_config(input logic [CfgW-1:0] win, input logic [CountW-1:0] thr,
                              input logic [CfgW-1:0] hold);
    settle();
    cfg_we    <= 1'b1;
    cfg_index <= REG_WINDOW_LENGTH;
    cfg_data  <= win;
    @(posedge clk);
    cfg_index <= REG_ALERT_THRESHOLD;
    cfg_data  <= {16'($urandom), thr};
    @(posedge clk);
    cfg_index <= REG_ALERT_HOLD;
    cfg_data  <= hold;
    @(posedge clk);
    // unused index must leave everything alone
    cfg_index <= REG_UNUSED;
    cfg_data  <= $urandom;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic frame_t random_frame(output bit counts);
    frame_t f;
    int     roll;
    if ($urandom_range(99) < 3) clock_ms = $urandom;
    else clock_ms = clock_ms + $urandom_range(25);
    roll = $urandom_range(99);
    f = frame_of(1'b0, 1'b1, 8'($urandom), random_mac(), '0, clock_ms,
                 SLOT_W'($urandom_range(TABLE_DEPTH - 1)));
    counts = 1'b1;
    if (roll < 60) begin
      // well-formed deauth or disassoc, mostly on a few busy access points
      f.fc = ($urandom_range(1) ? SUBTYPE_DEAUTH : SUBTYPE_DISASSOC) | 8'($urandom_range(3));
      if ($urandom_range(1)) f.rx = '1;
      if ($urandom_range(99) < 70) f.bssid = ap_pool[$urandom_range(3)];
      else f.bssid = ap_pool[$urandom_range(POOL_SIZE - 1)];
    end else if (roll < 80) begin
      f.cmd   = 1'b1;
      f.mgmt  = 1'($urandom);
      f.bssid = random_mac();
    end else begin
      counts = 1'b0;
      f.mgmt = 1'($urandom);
      case ($urandom_range(2))
        0: f.bssid = '0;
        1: f.bssid = ap_pool[$urandom_range(POOL_SIZE - 1)];
        default: f.bssid = random_mac();
      endcase
    end
    return f;
  endfunction

  task automatic random_block(input int wanted);
    frame_t f;
    bit     counts;
    int     done;
    done = 0;
    while (done < wanted) begin
      f = random_frame(counts);
      offer_frame(f);
      if (counts) done++;
    end
  endtask

  task automatic config_for_block(input int b);
    case (b)
      0: apply_config(32'd50, 16'd3, 32'd100);
      1: apply_config('0, '0, '0);
      3: apply_config('1, '1, '1);
      4: apply_config(32'd1, 16'd1, 32'd1);
      6: apply_config(32'd200, 16'd5, 32'd400);
      8: apply_config(WINDOW_RESET, THRESHOLD_RESET, HOLD_RESET);
      default: apply_config($urandom_range(400, 1), 16'($urandom_range(12, 1)),
                            $urandom_range(800, 1));
    endcase
  endtask

  initial begin
    logic [TimeW-1:0] t0;
    rst                       <= 1'b1;
    cfg_we                    <= 1'b0;
    cfg_index                 <= REG_WINDOW_LENGTH;
    cfg_data                  <= '0;
    frame_ch.valid            <= 1'b0;
    frame_ch.cmd              <= 1'b0;
    frame_ch.is_management    <= 1'b0;
    frame_ch.frame_control    <= '0;
    frame_ch.receiver_address <= '0;
    frame_ch.bssid_address    <= '0;
    frame_ch.time_ms          <= '0;
    frame_ch.entry_index      <= '0;
    send_idle_pct             <= 28;
    recv_idle_pct             <= 71;
    for (int i = 0; i < POOL_SIZE; i++) ap_pool[i] = random_mac() | MacW'(1);
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part on reset settings, times straddling the 32-bit wrap
    t0 = 32'hFFFF_FFF8;
    offer_frame(frame_of(1'b1, 1'b1, SUBTYPE_DEAUTH, '1, ap_pool[0], t0, '0));
    offer_frame(frame_of(1'b0, 1'b0, SUBTYPE_DEAUTH, '1, ap_pool[0], t0, '0));
    offer_frame(frame_of(1'b0, 1'b1, SUBTYPE_DEAUTH, '1, '0, t0, '0));
    offer_frame(frame_of(1'b0, 1'b1, SUBTYPE_DEAUTH | FC_TYPE_MASK, '1, ap_pool[0], t0, '0));
    offer_frame(frame_of(1'b0, 1'b1, SUBTYPE_BEACON, '1, ap_pool[0], t0, '0));
    offer_frame(frame_of(1'b0, 1'b1, SUBTYPE_DEAUTH, '1, ap_pool[0], t0, '0));
    offer_frame(frame_of(1'b0, 1'b1, SUBTYPE_DISASSOC, random_mac(), ap_pool[0], t0 + 1, '0));
    offer_frame(frame_of(1'b1, 1'b0, '0, '0, '0, t0 + 1, '0));
    // eight more distinct access points: the last one pushes out the first
    for (int i = 1; i <= TABLE_DEPTH; i++)
      offer_frame(frame_of(1'b0, 1'b1, SUBTYPE_DEAUTH, '1, ap_pool[i], t0 + 2 + i, '0));
    offer_frame(frame_of(1'b1, 1'b1, '1, '1, '1, '1, SLOT_W'(TABLE_DEPTH - 1)));
    // window long gone for this entry
    offer_frame(frame_of(1'b0, 1'b1, SUBTYPE_DISASSOC, '1, ap_pool[1], t0 + 2000, '0));
    offer_frame(frame_of(1'b0, 1'b1, '1, '1, '1, '1, '1));
    offer_frame(frame_of(1'b0, 1'b1, SUBTYPE_DEAUTH, '1, '1, t0 + 2001, '1));
    offer_frame(frame_of(1'b1, 1'b0, '0, '0, '0, t0 + 2001, '0));
    offer_frame(frame_of(1'b1, 1'b0, '0, '0, '0, t0 + 2001, SLOT_W'(TABLE_DEPTH - 1)));
    clock_ms = t0 + 2002;

    for (int ph = 0; ph < 3; ph++) begin
      settle();
      case (ph)
        0: begin
          send_idle_pct <= 28;
          recv_idle_pct <= 71;
        end
        1: begin
          send_idle_pct <= 71;
          recv_idle_pct <= 28;
        end
        default: begin
          send_idle_pct <= 0;
          recv_idle_pct <= 0;
        end
      endcase
      for (int b = 0; b < 3; b++) begin
        config_for_block(ph * 3 + b);
        random_block(RANDOM_ITEMS / BLOCKS);
      end
    end

    // read back every slot at the end
    for (int i = 0; i < TABLE_DEPTH; i++)
      offer_frame(frame_of(1'b1, 1'b1, '0, '0, '0, clock_ms + 1, SLOT_W'(i)));

    settle();
    repeat (10) @(posedge clk);
    if (errors == 0 && backlog == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
